// File: rtl/core/fan_curve_table_lookup_unit_macros.svh
// Assertion macros used by the fan curve lookup top module.
`ifndef FAN_CURVE_TABLE_LOOKUP_UNIT_MACROS_SVH
`define FAN_CURVE_TABLE_LOOKUP_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define FCTL_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed")
`define FCTL_ASSERT_DELAY3(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> ##3 (prop)) \
        else $error("assertion failed")
`else
`define FCTL_ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define FCTL_ASSERT_DELAY3(label, clk, rst_n, cond, prop)
`endif

`endif

// File: rtl/core/fctl_pkg.sv
package fctl_pkg;

    localparam int POINTS      = 20;
    localparam int CURVES      = 2;
    localparam int TOTAL_BYTES = CURVES * POINTS;
    localparam int IDX_W       = $clog2(POINTS);
    localparam int ADDR_W      = $clog2(TOTAL_BYTES);
    localparam int COUNT_W     = $clog2(TOTAL_BYTES + 1);
    localparam int TEMP_W      = 8;
    localparam int BYTE_W      = 8;
    localparam int DUTY_W      = 7;
    localparam int QUO_W       = 6;
    localparam int MAX_DUTY    = 100;
    localparam int DIV5_MUL    = 205;
    localparam int DIV5_SHIFT  = 10;
    localparam int PROD_W      = 16;
    localparam int CFG_IDX_W   = 1;

    localparam logic [TEMP_W-1:0] LOWEST_RESET  = 8'd25;
    localparam logic [TEMP_W-1:0] HIGHEST_RESET = 8'd120;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOWEST_TEMP  = 1'b0,
        CFG_HIGHEST_TEMP = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic              en;
        logic              bank;
        logic [ADDR_W-1:0] addr;
        logic [DUTY_W-1:0] data;
    } mem_wr_t;

    typedef struct packed {
        logic bank;
        logic use_default;
    } curve_sel_t;

    // Factory curve: two points at zero, then 30 rising by 10 and held at 100.
    function automatic logic [DUTY_W-1:0] default_duty(input logic [IDX_W-1:0] point);
        int pv;
        int dv;
        pv = int'(point);
        dv = 0;
        if (pv >= 2) begin
            dv = 30 + 10 * (pv - 2);
            if (dv > MAX_DUTY) begin
                dv = MAX_DUTY;
            end
        end
        return DUTY_W'(dv);
    endfunction

endpackage

// File: rtl/core/fctl_index.sv
module fctl_index (
    input  logic [fctl_pkg::TEMP_W-1:0] temperature,
    input  logic                        channel,
    input  logic [fctl_pkg::TEMP_W-1:0] lowest,
    input  logic [fctl_pkg::TEMP_W-1:0] highest,
    output logic [fctl_pkg::IDX_W-1:0]  point,
    output logic [fctl_pkg::ADDR_W-1:0] addr
);

    logic [fctl_pkg::TEMP_W-1:0] clamped;
    logic [fctl_pkg::TEMP_W-1:0] offset;
    logic [fctl_pkg::PROD_W-1:0] product;
    logic [fctl_pkg::QUO_W-1:0]  quotient;
    logic                        chan_sat;

    always_comb
    begin
        clamped = temperature;
        if (clamped < lowest)
        begin
            clamped = lowest;
        end
        if (clamped > highest)
        begin
            clamped = highest;
        end
        offset = (clamped >= lowest) ? (clamped - lowest) : '0;
    end

    // Division by five through a reciprocal, exact for all 8-bit offsets.
    assign product  = fctl_pkg::PROD_W'(offset) * fctl_pkg::PROD_W'(fctl_pkg::DIV5_MUL);
    assign quotient = product[fctl_pkg::DIV5_SHIFT +: fctl_pkg::QUO_W];

    always_comb
    begin
        if (quotient > fctl_pkg::QUO_W'(fctl_pkg::POINTS - 1))
        begin
            point = fctl_pkg::IDX_W'(fctl_pkg::POINTS - 1);
        end
        else
        begin
            point = fctl_pkg::IDX_W'(quotient);
        end
    end

    assign chan_sat = (fctl_pkg::CURVES > 1) ? channel : 1'b0;
    assign addr     = (chan_sat ? fctl_pkg::ADDR_W'(fctl_pkg::POINTS) : '0)
                    + fctl_pkg::ADDR_W'(point);

endmodule

// File: rtl/core/fctl_curve_mem.sv
module fctl_curve_mem (
    input  logic                        clk,
    input  fctl_pkg::mem_wr_t           wr,
    input  logic                        rd_en,
    input  logic                        rd_bank,
    input  logic [fctl_pkg::ADDR_W-1:0] rd_addr,
    output logic [fctl_pkg::DUTY_W-1:0] rd_data
);

    logic [fctl_pkg::DUTY_W-1:0] store_reg [2][fctl_pkg::TOTAL_BYTES];
    logic [fctl_pkg::DUTY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            store_reg[wr.bank][wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= store_reg[rd_bank][rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/fctl_loader.sv
module fctl_loader (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic [fctl_pkg::BYTE_W-1:0] curve_byte,
    input  logic                        last_byte,
    output fctl_pkg::mem_wr_t           wr,
    output fctl_pkg::curve_sel_t        sel,
    output logic                        load_ok
);

    logic [fctl_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [fctl_pkg::BYTE_W-1:0]  prev_reg, prev_next;
    logic                         err_reg, err_next;
    logic                         bank_reg, bank_next;
    logic                         dflt_reg, dflt_next;
    logic                         in_range;
    logic                         first_of_curve;
    logic                         err_acc;
    logic [fctl_pkg::COUNT_W-1:0] count_acc;

    assign in_range       = count_reg < fctl_pkg::COUNT_W'(fctl_pkg::TOTAL_BYTES);
    assign first_of_curve = (count_reg == '0)
                         || (count_reg == fctl_pkg::COUNT_W'(fctl_pkg::POINTS));

    always_comb
    begin
        err_acc   = err_reg;
        count_acc = count_reg;
        if (in_range)
        begin
            if (curve_byte > fctl_pkg::BYTE_W'(fctl_pkg::MAX_DUTY))
            begin
                err_acc = 1'b1;
            end
            if (!first_of_curve && (curve_byte < prev_reg))
            begin
                err_acc = 1'b1;
            end
            count_acc = count_reg + 1'b1;
        end
        else
        begin
            err_acc = 1'b1;
        end
        load_ok = !err_acc && (count_acc == fctl_pkg::COUNT_W'(fctl_pkg::TOTAL_BYTES));
    end

    always_comb
    begin
        count_next = count_reg;
        prev_next  = prev_reg;
        err_next   = err_reg;
        bank_next  = bank_reg;
        dflt_next  = dflt_reg;
        if (en)
        begin
            if (last_byte)
            begin
                count_next = '0;
                prev_next  = '0;
                err_next   = 1'b0;
                if (load_ok)
                begin
                    bank_next = !bank_reg;
                    dflt_next = 1'b0;
                end
            end
            else
            begin
                count_next = count_acc;
                prev_next  = curve_byte;
                err_next   = err_acc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            prev_reg  <= '0;
            err_reg   <= 1'b0;
            bank_reg  <= 1'b0;
            dflt_reg  <= 1'b1;
        end
        else
        begin
            count_reg <= count_next;
            prev_reg  <= prev_next;
            err_reg   <= err_next;
            bank_reg  <= bank_next;
            dflt_reg  <= dflt_next;
        end
    end

    // Loads fill the bank that lookups do not read; a commit swaps the banks.
    always_comb
    begin
        wr.en   = en && in_range;
        wr.bank = !bank_reg;
        wr.addr = count_reg[fctl_pkg::ADDR_W-1:0];
        wr.data = curve_byte[fctl_pkg::DUTY_W-1:0];
    end

    assign sel.bank        = bank_reg;
    assign sel.use_default = dflt_reg;

endmodule

// File: rtl/core/fan_curve_table_lookup_unit.sv
// An accepted word passes the s0 registers, the s1 and memory read registers, then the output registers.
// Throughput: one word per cycle, set by the one curve memory read or write that each word needs.
// busy stays low; the receiver cannot stall, so results are strobed for one cycle only.
// Reset restores the factory curves and the temperature range; the load state is cleared.
// The curve memory needs no clearing pass after reset.
`include "fan_curve_table_lookup_unit_macros.svh"

module fan_curve_table_lookup_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           kind,
    input  logic [fctl_pkg::BYTE_W-1:0]    curve_byte,
    input  logic                           last_byte,
    input  logic                           channel,
    input  logic [fctl_pkg::TEMP_W-1:0]    temperature,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fctl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fctl_pkg::TEMP_W-1:0]    cfg_data,
    output logic                           result_valid,
    output logic                           is_lookup_result,
    output logic [fctl_pkg::DUTY_W-1:0]    duty_percent,
    output logic                           curves_accepted
);

    logic                        accept;
    logic [fctl_pkg::TEMP_W-1:0] lowest_reg;
    logic [fctl_pkg::TEMP_W-1:0] highest_reg;

    logic                        s0_valid_reg;
    logic                        s0_kind_reg;
    logic [fctl_pkg::BYTE_W-1:0] s0_byte_reg;
    logic                        s0_last_reg;
    logic                        s0_chan_reg;
    logic [fctl_pkg::TEMP_W-1:0] s0_temp_reg;

    logic                        s1_valid_reg;
    logic                        s1_lookup_reg;
    logic                        s1_accepted_reg;
    logic                        s1_dflt_reg;
    logic [fctl_pkg::DUTY_W-1:0] s1_dflt_duty_reg;

    logic                        out_valid_reg;
    logic                        out_lookup_reg;
    logic [fctl_pkg::DUTY_W-1:0] out_duty_reg;
    logic                        out_accepted_reg;

    logic [fctl_pkg::IDX_W-1:0]  point;
    logic [fctl_pkg::ADDR_W-1:0] rd_addr;
    logic [fctl_pkg::DUTY_W-1:0] rd_data;
    logic                        load_en;
    logic                        lookup_en;
    logic                        load_ok;
    fctl_pkg::mem_wr_t           wr;
    fctl_pkg::curve_sel_t        sel;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_reg  <= fctl_pkg::LOWEST_RESET;
            highest_reg <= fctl_pkg::HIGHEST_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (fctl_pkg::cfg_reg_t'(cfg_index))
                fctl_pkg::CFG_LOWEST_TEMP:  lowest_reg  <= cfg_data;
                fctl_pkg::CFG_HIGHEST_TEMP: highest_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_kind_reg <= kind;
            s0_byte_reg <= curve_byte;
            s0_last_reg <= last_byte;
            s0_chan_reg <= channel;
            s0_temp_reg <= temperature;
        end
    end

    assign load_en   = s0_valid_reg && !s0_kind_reg;
    assign lookup_en = s0_valid_reg && s0_kind_reg;

    fctl_index u_index (
        .temperature (s0_temp_reg),
        .channel     (s0_chan_reg),
        .lowest      (lowest_reg),
        .highest     (highest_reg),
        .point       (point),
        .addr        (rd_addr)
    );

    fctl_loader u_loader (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (load_en),
        .curve_byte (s0_byte_reg),
        .last_byte  (s0_last_reg),
        .wr         (wr),
        .sel        (sel),
        .load_ok    (load_ok)
    );

    fctl_curve_mem u_mem (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (lookup_en),
        .rd_bank (sel.bank),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= lookup_en || (load_en && s0_last_reg);
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_lookup_reg    <= s0_kind_reg;
        s1_accepted_reg  <= !s0_kind_reg && load_ok;
        s1_dflt_reg      <= sel.use_default;
        s1_dflt_duty_reg <= fctl_pkg::default_duty(point);
        out_lookup_reg   <= s1_lookup_reg;
        out_accepted_reg <= s1_accepted_reg;
        if (!s1_lookup_reg)
        begin
            out_duty_reg <= '0;
        end
        else if (s1_dflt_reg)
        begin
            out_duty_reg <= s1_dflt_duty_reg;
        end
        else
        begin
            out_duty_reg <= rd_data;
        end
    end

    assign result_valid     = out_valid_reg;
    assign is_lookup_result = out_lookup_reg;
    assign duty_percent     = out_duty_reg;
    assign curves_accepted  = out_accepted_reg;

    `FCTL_ASSERT_IMPLY(a_status_zero_duty, clk, rst_n, result_valid && !is_lookup_result, duty_percent == '0);
    `FCTL_ASSERT_IMPLY(a_lookup_no_accept, clk, rst_n, result_valid && is_lookup_result, !curves_accepted);
    `FCTL_ASSERT_IMPLY(a_duty_in_range, clk, rst_n, result_valid, duty_percent <= fctl_pkg::DUTY_W'(fctl_pkg::MAX_DUTY));
    `FCTL_ASSERT_DELAY3(a_lookup_latency, clk, rst_n, start && kind, result_valid && is_lookup_result);

endmodule

// File: dv/fan_curve_table_lookup_unit_tb.sv
`timescale 1ns / 100ps

module fan_curve_table_lookup_unit_tb;
    import fctl_pkg::*;

    localparam int TEMP_STEP     = 5;
    localparam int MAX_LOAD      = TOTAL_BYTES + 6;
    localparam int RANDOM_WORDS  = 1550;
    localparam int PHASE_WORDS   = 150;
    localparam int DRAIN_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic              is_lookup;
        logic [DUTY_W-1:0] duty;
        logic              accepted;
    } fan_result_t;

    class fan_curve_scoreboard;
        logic [DUTY_W-1:0] active_curve [TOTAL_BYTES];
        logic [DUTY_W-1:0] shadow_curve [TOTAL_BYTES];
        int unsigned       bytes_loaded;
        logic [BYTE_W-1:0] prior_byte;
        bit                load_bad;
        logic [TEMP_W-1:0] lowest;
        logic [TEMP_W-1:0] highest;
        fan_result_t       pending_results [$];
        int                errors;

        function new();
            int duty;
            for (int p = 0; p < POINTS; p++)
            begin
                duty = 0;
                if (p >= 2)
                begin
                    duty = 30 + 10 * (p - 2);
                    if (duty > MAX_DUTY)
                    begin
                        duty = MAX_DUTY;
                    end
                end
                for (int c = 0; c < CURVES; c++)
                begin
                    active_curve[c * POINTS + p] = DUTY_W'(duty);
                end
            end
            foreach (shadow_curve[i])
            begin
                shadow_curve[i] = '0;
            end
            bytes_loaded = 0;
            prior_byte   = '0;
            load_bad     = 1'b0;
            lowest       = LOWEST_RESET;
            highest      = HIGHEST_RESET;
            errors       = 0;
        endfunction

        function void report(string what);
            $display("ERROR at %0t: %s", $realtime, what);
            errors++;
        endfunction

        function void write_register(cfg_reg_t idx, logic [TEMP_W-1:0] value);
            case (idx)
                CFG_LOWEST_TEMP:  lowest  = value;
                CFG_HIGHEST_TEMP: highest = value;
                default: ;
            endcase
        endfunction

        function void note_word(bit k, logic [BYTE_W-1:0] b, bit l, bit ch,
                                logic [TEMP_W-1:0] t);
            fan_result_t r;
            int          clamped;
            int          offset;
            int          point;
            int          curve;
            bit          ok;
            if (k)
            begin
                clamped = t;
                if (clamped < lowest)
                begin
                    clamped = lowest;
                end
                if (clamped > highest)
                begin
                    clamped = highest;
                end
                offset = (clamped >= lowest) ? clamped - lowest : 0;
                point  = offset / TEMP_STEP;
                if (point > POINTS - 1)
                begin
                    point = POINTS - 1;
                end
                curve = ch;
                if (curve > CURVES - 1)
                begin
                    curve = CURVES - 1;
                end
                r.is_lookup = 1'b1;
                r.duty      = active_curve[curve * POINTS + point];
                r.accepted  = 1'b0;
                pending_results.push_back(r);
                return;
            end
            if (bytes_loaded < TOTAL_BYTES)
            begin
                if (b > MAX_DUTY)
                begin
                    load_bad = 1'b1;
                end
                if ((bytes_loaded % POINTS) != 0 && b < prior_byte)
                begin
                    load_bad = 1'b1;
                end
                shadow_curve[bytes_loaded] = b[DUTY_W-1:0];
                bytes_loaded++;
            end
            else
            begin
                load_bad = 1'b1;
            end
            prior_byte = b;
            if (!l)
            begin
                return;
            end
            ok = !load_bad && bytes_loaded == TOTAL_BYTES;
            if (ok)
            begin
                active_curve = shadow_curve;
            end
            bytes_loaded = 0;
            prior_byte   = '0;
            load_bad     = 1'b0;
            r.is_lookup  = 1'b0;
            r.duty       = '0;
            r.accepted   = ok;
            pending_results.push_back(r);
        endfunction

        function void check_result(logic lk, logic [DUTY_W-1:0] d, logic acc);
            fan_result_t e;
            if (pending_results.size() == 0)
            begin
                report($sformatf("unexpected word lookup=%0b duty=%0d accepted=%0b",
                                 lk, d, acc));
                return;
            end
            e = pending_results.pop_front();
            if (lk !== e.is_lookup)
            begin
                report($sformatf("is_lookup_result %0b, want %0b", lk, e.is_lookup));
            end
            if (d !== e.duty)
            begin
                report($sformatf("duty_percent %0d, want %0d", d, e.duty));
            end
            if (acc !== e.accepted)
            begin
                report($sformatf("curves_accepted %0b, want %0b", acc, e.accepted));
            end
        endfunction

        function void check_drained();
            if (pending_results.size() > 0)
            begin
                report($sformatf("%0d expected words never arrived",
                                 pending_results.size()));
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 kind;
    logic [BYTE_W-1:0]    curve_byte;
    logic                 last_byte;
    logic                 channel;
    logic [TEMP_W-1:0]    temperature;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TEMP_W-1:0]    cfg_data;
    logic                 result_valid;
    logic                 is_lookup_result;
    logic [DUTY_W-1:0]    duty_percent;
    logic                 curves_accepted;

    fan_curve_scoreboard  sb = new();
    bit                   steady;
    int                   words_sent;
    int                   cycle_count;

    fan_curve_table_lookup_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .kind             (kind),
        .curve_byte       (curve_byte),
        .last_byte        (last_byte),
        .channel          (channel),
        .temperature      (temperature),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .result_valid     (result_valid),
        .is_lookup_result (is_lookup_result),
        .duty_percent     (duty_percent),
        .curves_accepted  (curves_accepted)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_valid === 1'b1)
        begin
            sb.check_result(is_lookup_result, duty_percent, curves_accepted);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_word(bit k, logic [BYTE_W-1:0] b, bit l, bit ch,
                             logic [TEMP_W-1:0] t);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 15);
        repeat (gap)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        start       = 1'b1;
        kind        = k;
        curve_byte  = b;
        last_byte   = l;
        channel     = ch;
        temperature = t;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_word(k, b, l, ch, t);
        words_sent++;
    endtask

    task automatic send_lookup(bit ch, logic [TEMP_W-1:0] t);
        send_word(1'b1, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), ch, t);
    endtask

    task automatic send_load(logic [BYTE_W-1:0] b, bit l);
        send_word(1'b0, b, l, 1'($urandom_range(0, 1)), TEMP_W'($urandom_range(0, 255)));
    endtask

    // Waits until every expected word has come and the pipeline has emptied.
    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        while (sb.pending_results.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [TEMP_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        sb.write_register(idx, value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_range(logic [TEMP_W-1:0] lo, logic [TEMP_W-1:0] hi);
        settle();
        write_reg(CFG_LOWEST_TEMP, lo);
        write_reg(CFG_HIGHEST_TEMP, hi);
    endtask

    // Half of the temperatures fall close to the configured range.
    function automatic logic [TEMP_W-1:0] pick_temp();
        int lo_edge;
        int hi_edge;
        if ($urandom_range(0, 1) == 0)
        begin
            return TEMP_W'($urandom_range(0, 255));
        end
        lo_edge = (sb.lowest < sb.highest) ? sb.lowest : sb.highest;
        hi_edge = (sb.lowest < sb.highest) ? sb.highest : sb.lowest;
        lo_edge = (lo_edge < 6) ? 0 : lo_edge - 6;
        hi_edge = (hi_edge > 249) ? 255 : hi_edge + 6;
        return TEMP_W'($urandom_range(lo_edge, hi_edge));
    endfunction

    // A clean load is two rising curves; the other kinds break one rule.
    task automatic run_load(int mode);
        logic [BYTE_W-1:0] bytes_q [MAX_LOAD];
        int                len;
        int                level;
        int                pos;
        for (int c = 0; c < CURVES; c++)
        begin
            level = $urandom_range(0, 30);
            for (int p = 0; p < POINTS; p++)
            begin
                if (p > 0)
                begin
                    level += $urandom_range(0, 8);
                end
                if (level > MAX_DUTY)
                begin
                    level = MAX_DUTY;
                end
                bytes_q[c * POINTS + p] = BYTE_W'(level);
            end
        end
        for (int i = TOTAL_BYTES; i < MAX_LOAD; i++)
        begin
            bytes_q[i] = BYTE_W'($urandom_range(0, 255));
        end
        len = TOTAL_BYTES;
        case (mode)
            1: bytes_q[$urandom_range(0, TOTAL_BYTES - 1)] =
                   BYTE_W'($urandom_range(MAX_DUTY + 1, 255));
            2:
            begin
                pos = $urandom_range(1, TOTAL_BYTES - 2);
                if (pos % POINTS == 0)
                begin
                    pos++;
                end
                if (bytes_q[pos - 1] == 0)
                begin
                    bytes_q[pos - 1] = 1;
                end
                bytes_q[pos] = BYTE_W'($urandom_range(0, bytes_q[pos - 1] - 1));
            end
            3: len = $urandom_range(1, TOTAL_BYTES - 1);
            4: len = $urandom_range(TOTAL_BYTES + 1, MAX_LOAD);
            default: ;
        endcase
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                send_lookup(1'($urandom_range(0, 1)), pick_temp());
            end
            send_load(bytes_q[i], i == len - 1);
        end
    endtask

    initial
    begin
        int sel;
        int phase;
        int phase_start;
        int lo;
        rst_n       = 1'b0;
        start       = 1'b0;
        kind        = 1'b0;
        curve_byte  = '0;
        last_byte   = 1'b0;
        channel     = 1'b0;
        temperature = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_LOWEST_TEMP;
        cfg_data    = '0;
        steady      = 1'b0;
        words_sent  = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_lookup(1'b0, 8'd0);
        send_lookup(1'b1, 8'd255);
        send_lookup(1'b0, 8'd25);
        send_lookup(1'b1, 8'd34);
        send_lookup(1'b0, 8'd35);
        send_lookup(1'b1, 8'd119);
        send_load(8'd255, 1'b1);
        send_load(8'd50, 1'b0);
        send_load(8'd40, 1'b1);
        send_load(8'd100, 1'b1);
        set_range(8'd200, 8'd100);
        send_lookup(1'b0, 8'd150);
        send_lookup(1'b1, 8'd255);
        set_range(8'd0, 8'd255);
        send_lookup(1'b0, 8'd255);
        send_lookup(1'b1, 8'd0);
        set_range(8'd255, 8'd0);
        send_lookup(1'b0, 8'd7);
        set_range(8'd0, 8'd0);
        send_lookup(1'b1, 8'd200);
        set_range(8'd255, 8'd255);
        send_lookup(1'b0, 8'd0);

        words_sent  = 0;
        phase       = 0;
        phase_start = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            if (words_sent >= phase_start)
            begin
                case (phase % 6)
                    0: set_range(LOWEST_RESET, HIGHEST_RESET);
                    1: set_range(8'd0, 8'd255);
                    2: set_range(8'd0, 8'd0);
                    3: set_range(8'd255, 8'd255);
                    4:
                    begin
                        lo = $urandom_range(1, 255);
                        set_range(TEMP_W'(lo), TEMP_W'($urandom_range(0, lo - 1)));
                    end
                    default:
                    begin
                        lo = $urandom_range(0, 200);
                        set_range(TEMP_W'(lo), TEMP_W'($urandom_range(lo, 255)));
                    end
                endcase
                phase++;
                phase_start = words_sent + PHASE_WORDS;
            end
            steady = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 9);
            if (sel <= 4)
            begin
                run_load(0);
            end
            else if (sel == 5)
            begin
                run_load($urandom_range(1, 4));
            end
            else if (sel <= 8)
            begin
                repeat ($urandom_range(5, 15))
                begin
                    send_lookup(1'($urandom_range(0, 1)), pick_temp());
                end
            end
            else
            begin
                repeat ($urandom_range(1, 10))
                begin
                    send_word(1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)),
                              ($urandom_range(0, 7) == 0), 1'($urandom_range(0, 1)),
                              TEMP_W'($urandom_range(0, 255)));
                end
                send_load(BYTE_W'($urandom_range(0, 255)), 1'b1);
            end
        end

        settle();
        sb.check_drained();
        if (sb.errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
